@@ rtl/core/lfhp_pkg.sv @@
// Package for the laser frame header parser.
// Holds the result type, the status codes and the sync word bytes.
// No dependencies.
`timescale 1ns / 1ps

package lfhp_pkg;

  typedef enum logic [1:0] {
    STATUS_FULL  = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_ERROR = 2'd2
  } status_e;

  localparam logic [7:0]  SYNC_I      = 8'h49;
  localparam logic [7:0]  SYNC_L      = 8'h4C;
  localparam logic [7:0]  SYNC_D      = 8'h44;
  localparam logic [7:0]  SYNC_A      = 8'h41;
  localparam logic [31:0] CNT_MAX     = 32'hFFFF_FFFF;
  localparam logic [31:0] FORMAT_MAX  = 32'd5;
  localparam logic [31:0] SHORT_LEN   = 32'd16;
  localparam logic [31:0] FULL_LEN    = 32'd32;

  typedef struct packed {
    status_e     status;
    logic [2:0]  record_format;
    logic [63:0] frame_name;
    logic [63:0] company_name;
    logic [31:0] item_quantity;
    logic [15:0] frame_number;
    logic [15:0] frame_total;
    logic [7:0]  scanner_head;
    logic [7:0]  reserved_byte;
    logic [31:0] skipped_bytes;
  } result_t;

  function automatic logic [7:0] sync_byte(input logic [1:0] pos);
    logic [7:0] val;
    case (pos)
      2'd0:    val = SYNC_I;
      2'd1:    val = SYNC_L;
      2'd2:    val = SYNC_D;
      default: val = SYNC_A;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/core/lfhp_parser.sv @@
// Phase machine and field shift registers of the laser frame header parser.
// Produces at most one result per accepted byte. Depends on lfhp_pkg.
`timescale 1ns / 1ps

module lfhp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_stream_i,
  input  logic              short_detect_i,
  output logic              res_valid_o,
  output lfhp_pkg::result_t res_o
);

  localparam logic [2:0] PH_SYNC   = 3'd0;
  localparam logic [2:0] PH_FORMAT = 3'd1;
  localparam logic [2:0] PH_NAME   = 3'd2;
  localparam logic [2:0] PH_OWNER  = 3'd3;
  localparam logic [2:0] PH_TAIL   = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  sync_q, sync_d;
  logic [2:0]  idx_q, idx_d;
  logic [31:0] fmt_q, fmt_d;
  logic [63:0] name_q, name_d;
  logic [63:0] owner_q, owner_d;
  logic [55:0] tail_q, tail_d;
  logic [31:0] cnt_q, cnt_d;

  logic [31:0] cnt_inc;
  logic [31:0] fmt_next;
  logic [63:0] name_next;
  logic [34:0] short_rhs;
  logic        short_hit;

  assign cnt_inc   = (cnt_q == lfhp_pkg::CNT_MAX) ? cnt_q : cnt_q + 32'd1;
  assign fmt_next  = {fmt_q[23:0], data_byte_i};
  assign name_next = {name_q[55:0], data_byte_i};
  // Three times the low word plus four, kept wide so that nothing wraps.
  assign short_rhs = {2'b00, name_next[31:0], 1'b0} + {3'b000, name_next[31:0]} + 35'd4;
  assign short_hit = short_detect_i && ({3'b000, name_next[63:32]} == short_rhs);

  always_comb begin
    logic clear;
    clear       = 1'b0;
    phase_d     = phase_q;
    sync_d      = sync_q;
    idx_d       = idx_q;
    fmt_d       = fmt_q;
    name_d      = name_q;
    owner_d     = owner_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      cnt_d = cnt_inc;
      case (phase_q)
        PH_SYNC: begin
          if (data_byte_i == lfhp_pkg::sync_byte(sync_q)) begin
            if (sync_q == 2'd3) begin
              sync_d  = 2'd0;
              phase_d = PH_FORMAT;
              idx_d   = 3'd0;
              fmt_d   = '0;
            end else begin
              sync_d = sync_q + 2'd1;
            end
          end else begin
            // A mismatching 'I' already starts the next match.
            sync_d = (data_byte_i == lfhp_pkg::SYNC_I) ? 2'd1 : 2'd0;
          end
        end
        PH_FORMAT: begin
          fmt_d = fmt_next;
          if (idx_q == 3'd3) begin
            idx_d = 3'd0;
            if (fmt_next <= lfhp_pkg::FORMAT_MAX) begin
              phase_d = PH_NAME;
              name_d  = '0;
            end else begin
              phase_d = PH_SYNC;
              sync_d  = 2'd0;
              fmt_d   = '0;
            end
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
        PH_NAME: begin
          name_d = name_next;
          if (idx_q == 3'd7) begin
            idx_d = 3'd0;
            if (short_hit) begin
              res_valid_o         = 1'b1;
              res_o.status        = lfhp_pkg::STATUS_SHORT;
              res_o.record_format = fmt_q[2:0];
              res_o.frame_name    = name_next;
              res_o.item_quantity = name_next[31:0];
              res_o.skipped_bytes = (cnt_inc == lfhp_pkg::CNT_MAX) ? lfhp_pkg::CNT_MAX
                                    : cnt_inc - lfhp_pkg::SHORT_LEN;
              clear               = 1'b1;
            end else begin
              phase_d = PH_OWNER;
              owner_d = '0;
            end
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
        PH_OWNER: begin
          owner_d = {owner_q[55:0], data_byte_i};
          if (idx_q == 3'd7) begin
            idx_d   = 3'd0;
            phase_d = PH_TAIL;
            tail_d  = '0;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
        PH_TAIL: begin
          if (idx_q == 3'd7) begin
            res_valid_o         = 1'b1;
            res_o.status        = lfhp_pkg::STATUS_FULL;
            res_o.record_format = fmt_q[2:0];
            res_o.frame_name    = name_q;
            res_o.company_name  = owner_q;
            res_o.item_quantity = {16'd0, tail_q[55:40]};
            res_o.frame_number  = tail_q[39:24];
            res_o.frame_total   = tail_q[23:8];
            res_o.scanner_head  = tail_q[7:0];
            res_o.reserved_byte = data_byte_i;
            res_o.skipped_bytes = (cnt_inc == lfhp_pkg::CNT_MAX) ? lfhp_pkg::CNT_MAX
                                  : cnt_inc - lfhp_pkg::FULL_LEN;
            clear               = 1'b1;
          end else begin
            tail_d = {tail_q[47:0], data_byte_i};
            idx_d  = idx_q + 3'd1;
          end
        end
        default: begin
          clear = 1'b1;
        end
      endcase
      if (end_of_stream_i && !res_valid_o) begin
        res_valid_o         = 1'b1;
        res_o               = '0;
        res_o.status        = lfhp_pkg::STATUS_ERROR;
        res_o.skipped_bytes = cnt_inc;
        clear               = 1'b1;
      end
      if (clear) begin
        phase_d = PH_SYNC;
        sync_d  = '0;
        idx_d   = '0;
        fmt_d   = '0;
        name_d  = '0;
        owner_d = '0;
        tail_d  = '0;
        cnt_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC;
      sync_q  <= '0;
      idx_q   <= '0;
      fmt_q   <= '0;
      name_q  <= '0;
      owner_q <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      sync_q  <= sync_d;
      idx_q   <= idx_d;
      fmt_q   <= fmt_d;
      name_q  <= name_d;
      owner_q <= owner_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ rtl/core/lfhp_out_buf.sv @@
// Result register with a skid stage for the laser frame header parser.
// Decouples the result handshake from byte intake. Depends on lfhp_pkg.
`timescale 1ns / 1ps

module lfhp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lfhp_pkg::result_t push_data_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lfhp_pkg::result_t out_data_o
);

  logic              main_valid_q, main_valid_d;
  logic              skid_valid_q, skid_valid_d;
  lfhp_pkg::result_t main_q, main_d;
  lfhp_pkg::result_t skid_q, skid_d;
  logic              pop;

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;
  assign pop         = main_valid_q && out_ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

@@ rtl/core/laser_frame_header_parser.sv @@
// Top level of the laser frame header parser.
// Instantiates lfhp_parser and lfhp_out_buf; depends on lfhp_pkg.
`timescale 1ns / 1ps

// The parser takes one byte per transaction and accepts a byte in every
// clock cycle in which the skid stage is empty. Each byte advances the phase
// machine and the field shift registers in the same cycle in which it is
// accepted; a result caused by a byte is registered into the output register,
// or into the skid stage behind it while that register holds an untaken
// result, so bytes keep flowing while one finished header waits to be taken;
// intake stalls only when both the output register and the skid stage hold a
// result. The search looks for the sync word "ILDA" with overlapping match,
// then reads the format word (codes 0 to 5 accepted, others restart the
// search), the name, and either reports a short palette header (when enabled
// through the configuration register and the name words fit that form) or
// continues through the owner, quantity, identity, total, scanner and
// reserved bytes. A byte flagged as end of stream that does not complete a
// header produces an error result carrying the count of bytes consumed. The
// short palette detection enable resets to one and should be written only
// while the block is idle.

module laser_frame_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [2:0]  record_format_o,
  output logic [63:0] frame_name_o,
  output logic [63:0] company_name_o,
  output logic [31:0] item_quantity_o,
  output logic [15:0] frame_number_o,
  output logic [15:0] frame_total_o,
  output logic [7:0]  scanner_head_o,
  output logic [7:0]  reserved_byte_o,
  output logic [31:0] skipped_bytes_o
);

  logic              short_detect_q;
  logic              accept;
  logic              res_valid;
  lfhp_pkg::result_t res;
  lfhp_pkg::result_t out_res;

  // Configuration register; writes are expected only while idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_detect_q <= 1'b1;
    end else if (cfg_we_i) begin
      short_detect_q <= cfg_wdata_i;
    end
  end

  // A byte transaction completes when the buffer has room for a result.
  assign accept = in_valid_i && in_ready_o;

  lfhp_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .short_detect_i  (short_detect_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  // The buffer is never full when a byte is taken, so a push always fits.
  lfhp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign status_o        = out_res.status;
  assign record_format_o = out_res.record_format;
  assign frame_name_o    = out_res.frame_name;
  assign company_name_o  = out_res.company_name;
  assign item_quantity_o = out_res.item_quantity;
  assign frame_number_o  = out_res.frame_number;
  assign frame_total_o   = out_res.frame_total;
  assign scanner_head_o  = out_res.scanner_head;
  assign reserved_byte_o = out_res.reserved_byte;
  assign skipped_bytes_o = out_res.skipped_bytes;

endmodule
